// ===== rtl/ptg_pkg.sv =====
// Package for the pulse train generator: item types, codes and constants.
package ptg_pkg;

  // Field widths
  localparam int COUNT_W    = 32;
  localparam int REQ_W      = 16;
  localparam int LIMIT_W    = 10;
  localparam int HALF_W     = 20;
  localparam int ELAPSED_W  = 48;
  localparam int MS_W       = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  // Defaults
  localparam int TICKS_PER_MS_DEFAULT = 1000;
  localparam logic [LIMIT_W-1:0] MIN_WIDTH_RESET = LIMIT_W'(30);
  localparam logic [LIMIT_W-1:0] MAX_WIDTH_RESET = LIMIT_W'(300);

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TICK     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 1'd1;

  typedef struct packed {
    logic               command;
    logic [COUNT_W-1:0] pulse_count;
    logic [REQ_W-1:0]   width_ms;
  } ptg_in_t;

  typedef struct packed {
    logic                pulse_level;
    logic                busy_flag;
    logic [STATUS_W-1:0] status;
    logic                done_flag;
    logic [COUNT_W-1:0]  done_count;
    logic [MS_W-1:0]     done_ms;
  } ptg_out_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] min_width_ms;
    logic [LIMIT_W-1:0] max_width_ms;
  } ptg_limits_t;

endpackage

// ===== rtl/ptg_core.sv =====
// Train state and per-item result logic of the pulse train generator.
module ptg_core import ptg_pkg::*; #(
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  ptg_in_t     item,
  input  ptg_limits_t limits,
  output ptg_out_t    result
);

  localparam int PROD_W = LIMIT_W + $clog2(TICKS_PER_MS + 1);
  localparam int REM_W  = $clog2(TICKS_PER_MS + 1);

  // Train state
  logic                 level, level_next;
  logic                 running, running_next;
  logic [COUNT_W-1:0]   pulses_left, pulses_left_next;
  logic [HALF_W-1:0]    half_period, half_period_next;
  logic [HALF_W-1:0]    half_counter, half_counter_next;
  logic [COUNT_W-1:0]   requested_count, requested_count_next;
  logic [ELAPSED_W-1:0] elapsed_ticks, elapsed_ticks_next;
  // Quotient and remainder of elapsed_ticks by TICKS_PER_MS, kept incrementally
  logic [MS_W-1:0]      ms_count, ms_count_next;
  logic [REM_W-1:0]     rem_count, rem_count_next;

  // Width clamp and half period
  logic [REQ_W-1:0]   width_raised;
  logic [LIMIT_W-1:0] width_clamped;
  logic [PROD_W-1:0]  half_product;
  logic [HALF_W-1:0]  half_inc;
  logic [COUNT_W-1:0] pulses_dec;

  always_comb begin
    width_raised = (item.width_ms < REQ_W'(limits.min_width_ms)) ?
                   REQ_W'(limits.min_width_ms) : item.width_ms;
    width_clamped = (width_raised > REQ_W'(limits.max_width_ms)) ?
                    limits.max_width_ms : width_raised[LIMIT_W-1:0];
    half_product = PROD_W'(width_clamped) * PROD_W'(TICKS_PER_MS);
  end

  // Next state and result
  always_comb begin
    level_next           = level;
    running_next         = running;
    pulses_left_next     = pulses_left;
    half_period_next     = half_period;
    half_counter_next    = half_counter;
    requested_count_next = requested_count;
    elapsed_ticks_next   = elapsed_ticks;
    ms_count_next        = ms_count;
    rem_count_next       = rem_count;
    half_inc             = half_counter + HALF_W'(1);
    pulses_dec           = pulses_left;
    result               = '0;

    if (item.command == CMD_START) begin
      if (running) begin
        result.status = ST_BUSY;
      end else if (item.pulse_count == '0) begin
        result.status = ST_ZERO;
      end else begin
        half_period_next     = HALF_W'(half_product);
        half_counter_next    = '0;
        pulses_left_next     = item.pulse_count;
        requested_count_next = item.pulse_count;
        level_next           = 1'b0;
        elapsed_ticks_next   = '0;
        ms_count_next        = '0;
        rem_count_next       = '0;
        running_next         = 1'b1;
        result.status        = ST_ACCEPTED;
      end
    end else begin
      result.status = ST_TICK;
      if (running) begin
        // elapsed time: wraps with the 48-bit tick count
        elapsed_ticks_next = elapsed_ticks + ELAPSED_W'(1);
        if (elapsed_ticks == '1) begin
          ms_count_next  = '0;
          rem_count_next = '0;
        end else if (rem_count == REM_W'(TICKS_PER_MS - 1)) begin
          ms_count_next  = ms_count + MS_W'(1);
          rem_count_next = '0;
        end else begin
          rem_count_next = rem_count + REM_W'(1);
        end
        // half period expiry toggles the pin; a falling edge uses a pulse
        half_counter_next = half_inc;
        if (half_inc >= half_period) begin
          half_counter_next = '0;
          level_next        = ~level;
          if (level) begin
            if (pulses_left != '0) pulses_dec = pulses_left - COUNT_W'(1);
            pulses_left_next = pulses_dec;
            if (pulses_dec == '0) begin
              running_next      = 1'b0;
              level_next        = 1'b0;
              result.done_flag  = 1'b1;
              result.done_count = requested_count;
              result.done_ms    = ms_count_next;
            end
          end
        end
      end
    end

    result.pulse_level = level_next;
    result.busy_flag   = running_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level           <= 1'b0;
      running         <= 1'b0;
      pulses_left     <= '0;
      half_period     <= '0;
      half_counter    <= '0;
      requested_count <= '0;
      elapsed_ticks   <= '0;
      ms_count        <= '0;
      rem_count       <= '0;
    end else if (enable) begin
      level           <= level_next;
      running         <= running_next;
      pulses_left     <= pulses_left_next;
      half_period     <= half_period_next;
      half_counter    <= half_counter_next;
      requested_count <= requested_count_next;
      elapsed_ticks   <= elapsed_ticks_next;
      ms_count        <= ms_count_next;
      rem_count       <= rem_count_next;
    end
  end

endmodule

// ===== rtl/pulse_train_generator.sv =====
// An accepted item goes through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; the result and input registers
// each hold one item, so a new item is taken while a finished result waits to be taken.
// Elapsed milliseconds come from a running quotient/remainder counter pair, no divider.
// Reset (synchronous, rst high): train idle, pin low, limits 30 ms and 300 ms, both empty.
module pulse_train_generator import ptg_pkg::*; #(
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptg_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptg_out_t             out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  ptg_limits_t limits;
  logic        s1_valid;
  ptg_in_t     s1_item;
  ptg_out_t    result;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  // Handshake control
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.min_width_ms <= MIN_WIDTH_RESET;
      limits.max_width_ms <= MAX_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_WIDTH: limits.min_width_ms <= cfg_data;
        CFG_MAX_WIDTH: limits.max_width_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_item <= in_item;
  end

  // Train state and result logic
  ptg_core #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .enable (advance),
    .item   (s1_item),
    .limits (limits),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= result;
  end

`ifndef NO_ASSERTIONS
  // done is only reported by the tick that stops the train
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_flag |-> !out_item.busy_flag && out_item.status == ST_TICK)
    else $error("done reported while train still busy or on a request");

  // an idle train always drives the pin low
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.busy_flag |-> !out_item.pulse_level)
    else $error("pin high while train idle");

  // input side only stalls when the result register is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled without a held result");

  // a held result does not move to a new item
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result lost or changed");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the pulse train generator: random handshakes, predicted results.
`timescale 1ns / 100ps

module testbench;
  import ptg_pkg::*;

  localparam int TICKS       = TICKS_PER_MS_DEFAULT;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int PRINT_LIMIT = 100;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  ptg_in_t              in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ptg_out_t             out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_WIDTH;
  logic [LIMIT_W-1:0]   cfg_data  = '0;

  pulse_train_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Width limits as the block holds them, and the shadow train state
  logic [LIMIT_W-1:0]   lim_lo = MIN_WIDTH_RESET;
  logic [LIMIT_W-1:0]   lim_hi = MAX_WIDTH_RESET;
  logic                 pin    = 1'b0;
  logic                 active = 1'b0;
  logic [COUNT_W-1:0]   left      = '0;
  logic [COUNT_W-1:0]   count_req = '0;
  logic [HALF_W-1:0]    half_len  = '0;
  logic [HALF_W-1:0]    half_pos  = '0;
  logic [ELAPSED_W-1:0] ticks_run = '0;

  ptg_in_t  items_to_send[$];
  ptg_out_t outputs_due[$];

  longint unsigned train_ticks_left = 0;
  int unsigned     mismatches   = 0;
  int unsigned     results_seen = 0;
  int unsigned     cycles       = 0;
  bit              item_taken   = 1'b0;
  bit              result_taken = 1'b0;
  int unsigned     send_gap   = 0;
  int unsigned     stall_left = 0;
  bit              send_calm  = 1'b0;
  bit              take_calm  = 1'b0;

  // Clamp a requested width and turn it into half-period ticks
  function automatic logic [HALF_W-1:0] half_ticks(input logic [REQ_W-1:0] w,
                                                   input logic [LIMIT_W-1:0] lo,
                                                   input logic [LIMIT_W-1:0] hi);
    logic [31:0] ms;
    ms = 32'(w);
    if (ms < 32'(lo)) ms = 32'(lo);
    if (ms > 32'(hi)) ms = 32'(hi);
    return HALF_W'(ms * TICKS);
  endfunction

  // Next result of the train for one accepted item
  function automatic ptg_out_t advance_train(input ptg_in_t it);
    ptg_out_t r;
    r = '0;
    if (it.command == CMD_START) begin
      if (active) begin
        r.status = ST_BUSY;
      end else if (it.pulse_count == '0) begin
        r.status = ST_ZERO;
      end else begin
        half_len  = half_ticks(it.width_ms, lim_lo, lim_hi);
        half_pos  = '0;
        left      = it.pulse_count;
        count_req = it.pulse_count;
        pin       = 1'b0;
        ticks_run = '0;
        active    = 1'b1;
        r.status  = ST_ACCEPTED;
      end
    end else begin
      r.status = ST_TICK;
      if (active) begin
        ticks_run = ticks_run + 1'b1;
        half_pos  = half_pos + 1'b1;
        if (half_pos >= half_len) begin
          half_pos = '0;
          pin = ~pin;
          // a falling edge uses up one pulse
          if (!pin) begin
            if (left != '0) left = left - 1'b1;
            if (left == '0) begin
              active       = 1'b0;
              pin          = 1'b0;
              r.done_flag  = 1'b1;
              r.done_count = count_req;
              r.done_ms    = MS_W'(ticks_run / ELAPSED_W'(TICKS));
            end
          end
        end
      end
    end
    r.pulse_level = pin;
    r.busy_flag   = active;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch on result %0d: %s", results_seen, msg);
  endtask

  task automatic check_result(input ptg_out_t got);
    ptg_out_t want;
    results_seen++;
    if (outputs_due.size() == 0) begin
      report_mismatch("result arrived with nothing due");
      return;
    end
    want = outputs_due.pop_front();
    if (got.pulse_level !== want.pulse_level)
      report_mismatch($sformatf("pulse_level got %0h want %0h", got.pulse_level,
                                want.pulse_level));
    if (got.busy_flag !== want.busy_flag)
      report_mismatch($sformatf("busy_flag got %0h want %0h", got.busy_flag, want.busy_flag));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0h want %0h", got.status, want.status));
    if (got.done_flag !== want.done_flag)
      report_mismatch($sformatf("done_flag got %0h want %0h", got.done_flag, want.done_flag));
    if (got.done_count !== want.done_count)
      report_mismatch($sformatf("done_count got %0h want %0h", got.done_count,
                                want.done_count));
    if (got.done_ms !== want.done_ms)
      report_mismatch($sformatf("done_ms got %0h want %0h", got.done_ms,
                                want.done_ms));
  endtask

  // Sampling at the rising edge: accept items, predict, check results
  always @(posedge clk) begin
    cycles++;
    item_taken   = !rst && in_valid && !in_stall;
    result_taken = !rst && out_valid && !out_stall;
    if (rst) begin
      lim_lo    = MIN_WIDTH_RESET;
      lim_hi    = MAX_WIDTH_RESET;
      pin       = 1'b0;
      active    = 1'b0;
      left      = '0;
      count_req = '0;
      half_len  = '0;
      half_pos  = '0;
      ticks_run = '0;
    end else begin
      if (item_taken) outputs_due.push_back(advance_train(in_item));
      if (result_taken) check_result(out_item);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Item driver, falling edge; a presented item holds until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        in_item  <= items_to_send.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall, drawn afresh for every result
  always @(negedge clk) begin
    if (result_taken) begin
      if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
      stall_left = take_calm ? 0 : $urandom_range(0, 3);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Queue one item and track how many ticks the running train still needs
  task automatic queue_item(input logic cmd, input logic [COUNT_W-1:0] n,
                            input logic [REQ_W-1:0] w);
    ptg_in_t           it;
    logic [HALF_W-1:0] h;
    it.command     = cmd;
    it.pulse_count = n;
    it.width_ms    = w;
    items_to_send.push_back(it);
    if (cmd == CMD_TICK) begin
      if (train_ticks_left != 0) train_ticks_left--;
    end else if (train_ticks_left == 0 && n != '0) begin
      h = half_ticks(w, lim_lo, lim_hi);
      train_ticks_left = 2 * 64'(n) * ((h == '0) ? 64'd1 : 64'(h));
    end
  endtask

  // Stray requests: rejected while a train runs, zero count or idle ticks otherwise
  task automatic queue_noise();
    logic [COUNT_W-1:0] n;
    case ($urandom_range(0, 3))
      0:       n = '0;
      1:       n = '1;
      default: n = $urandom;
    endcase
    if (train_ticks_left != 0) begin
      queue_item(CMD_START, n, REQ_W'($urandom));
    end else if ($urandom_range(0, 1) == 0) begin
      queue_item(CMD_START, '0, REQ_W'($urandom));
    end else begin
      queue_item(CMD_TICK, $urandom, REQ_W'($urandom));
    end
  endtask

  // One full train: start, ticks up to done with stray requests, a few idle ticks
  task automatic queue_train(input logic [COUNT_W-1:0] n, input logic [REQ_W-1:0] w,
                             input int unsigned odds);
    repeat ($urandom_range(0, 2)) queue_noise();
    queue_item(CMD_START, n, w);
    while (train_ticks_left != 0) begin
      if ($urandom_range(1, odds) == 1) queue_noise();
      else queue_item(CMD_TICK, $urandom, REQ_W'($urandom));
    end
    repeat ($urandom_range(0, 3)) queue_item(CMD_TICK, $urandom, REQ_W'($urandom));
  endtask

  // Wait until every item is sent and every result is in
  task automatic settle();
    @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || outputs_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both width limits; called on a falling edge with the block idle
  task automatic set_limits(input logic [LIMIT_W-1:0] lo, input logic [LIMIT_W-1:0] hi);
    cfg_index <= CFG_MIN_WIDTH;
    cfg_data  <= lo;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_lo = lo;
    @(negedge clk);
    cfg_index <= CFG_MAX_WIDTH;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_hi = hi;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limits: idle ticks and zero counts only; any train here lasts 60000 ticks or more
    queue_item(CMD_TICK, '1, '1);
    queue_item(CMD_START, '0, 16'd5);
    queue_item(CMD_START, '0, '1);
    queue_item(CMD_START, '0, '0);
    queue_item(CMD_TICK, 32'h5555_5555, 16'haaaa);
    queue_item(CMD_START, '0, 16'h8000);
    settle();

    // Zero limits: half period of zero, one toggle per tick; busy wins over zero count
    set_limits('0, '0);
    queue_item(CMD_START, 32'd2, '1);
    queue_item(CMD_START, '0, '0);
    repeat (4) queue_item(CMD_TICK, '0, '1);
    queue_item(CMD_TICK, '0, '0);
    repeat (3) begin
      queue_train(($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6),
                  REQ_W'($urandom), 6);
    end
    // 500 pulses take exactly 1000 ticks, so done reports one millisecond
    queue_train(32'd500, REQ_W'($urandom), 40);
    settle();

    // Crossed limits: the upper one wins
    set_limits(10'd1000, 10'd0);
    repeat (2) queue_train($urandom_range(1, 2), REQ_W'($urandom), 6);
    settle();

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptg_pkg.sv
rtl/ptg_core.sv
rtl/pulse_train_generator.sv
verif/testbench.sv
